FILE: hw/rtl/apq_pkg.sv
// shared types, codes and the age class function for the age priority queue
package apq_pkg;

	localparam int unsigned DEPTH_DEF = 16;
	localparam int unsigned TAG_W     = 16;
	localparam int unsigned AGE_W     = 8;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned PRI_W     = 3;
	localparam int unsigned OCC_W     = 5;
	localparam int unsigned IN_DATA_W  = 24;
	localparam int unsigned OUT_DATA_W = 32;
	localparam int unsigned OUT_USER_W = 3;

	typedef enum logic [KIND_W-1:0] {
		KIND_ENQ  = 2'd0,
		KIND_DEQ  = 2'd1,
		KIND_PEEK = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2,
		STATUS_RSVD  = 2'd3
	} status_t;

	// request broadcast to every cell of the row
	typedef struct packed {
		logic             enq;
		logic             deq;
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} apq_ctrl_t;

	// what one cell shows its neighbours
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
		logic             go;   // occupied and younger than the new entry: moves back
		logic             keep; // occupied and not younger: stays in place
	} apq_link_t;

	// priority class of an age
	function automatic logic [PRI_W-1:0] age_class(input logic [AGE_W-1:0] a);
		logic [PRI_W-1:0] c;
		if (a >= 8'd100)     c = 3'd5;
		else if (a >= 8'd90) c = 3'd4;
		else if (a >= 8'd80) c = 3'd3;
		else if (a >= 8'd70) c = 3'd2;
		else if (a >= 8'd60) c = 3'd1;
		else                 c = 3'd0;
		return c;
	endfunction

endpackage

FILE: hw/rtl/apq_cell.sv
// one storage cell of the sorted row: holds one entry and shifts with its neighbours
module apq_cell (
	input  logic               clk,
	input  apq_pkg::apq_ctrl_t ctrl,
	input  logic               occ,
	input  apq_pkg::apq_link_t prev,
	input  apq_pkg::apq_link_t next,
	output apq_pkg::apq_link_t cur
);
	import apq_pkg::*;

	logic [TAG_W-1:0] tag_q;
	logic [AGE_W-1:0] age_q;
	logic             go;
	logic             keep;

	// compare against the incoming age
	assign go   = occ && (age_q < ctrl.age);
	assign keep = occ && !go;

	assign cur.tag  = tag_q;
	assign cur.age  = age_q;
	assign cur.go   = go;
	assign cur.keep = keep;

	// insert, shift back on enqueue, shift forward on dequeue
	always_ff @(posedge clk) begin
		if (ctrl.enq) begin
			if (prev.go) begin
				tag_q <= prev.tag;
				age_q <= prev.age;
			end else if (prev.keep && !keep) begin
				tag_q <= ctrl.tag;
				age_q <= ctrl.age;
			end
		end else if (ctrl.deq) begin
			tag_q <= next.tag;
			age_q <= next.age;
		end
	end

endmodule

FILE: hw/rtl/age_priority_queue.sv
// top level of the age priority queue: cell row, entry count and result register
//
// channel  dir  beat fields (lowest bit first)
// s_*      in   tdata: tag[15:0], age[23:16]; tuser: kind[1:0]
// m_*      out  tdata: head_tag[15:0], head_age[23:16], head_priority[26:24],
//                      occupancy[31:27]; tuser: status[1:0], item_valid[2]
//
// one request per cycle while the output is not stalled: the cell row inserts, shifts
// or reads the head in the cycle a beat is accepted, and the result is in the output register next cycle.
// a new beat is taken while no result is held or the held result is being taken (m_tready high).
// reset clears the entry count and the output valid; cell contents are undefined.
// a stalled output holds the result and stops further requests.
module age_priority_queue #(
	parameter int unsigned DEPTH = apq_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [apq_pkg::IN_DATA_W-1:0]       s_tdata,  // tag, age
	input  logic [apq_pkg::KIND_W-1:0]          s_tuser,  // kind
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [apq_pkg::OUT_DATA_W-1:0]      m_tdata,  // head_tag, head_age, head_priority, occupancy
	output logic [apq_pkg::OUT_USER_W-1:0]      m_tuser   // status, item_valid
);
	import apq_pkg::*;

	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             take;
	kind_t            kind;
	logic             full;
	logic             empty;
	apq_ctrl_t        ctrl;
	apq_link_t        links [DEPTH];
	apq_link_t        head_prev;
	apq_link_t        tail_next;
	logic [CNT_W-1:0] cnt_nxt;
	status_t          status_nxt;
	logic             valid_nxt;

	logic [TAG_W-1:0]    head_tag_q;
	logic [AGE_W-1:0]    head_age_q;
	logic [PRI_W-1:0]    head_pri_q;
	logic [OCC_W-1:0]    occ_q;
	status_t             status_q;
	logic                item_valid_q;

	// input handshake
	assign s_tready = !m_tvalid || m_tready;
	assign take     = s_tvalid && s_tready;
	assign kind     = kind_t'(s_tuser);
	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);

	// request broadcast
	assign ctrl.enq = take && (kind == KIND_ENQ) && !full;
	assign ctrl.deq = take && (kind == KIND_DEQ) && !empty;
	assign ctrl.tag = s_tdata[TAG_W-1:0];
	assign ctrl.age = s_tdata[TAG_W +: AGE_W];

	// row ends
	assign head_prev = '{tag: '0, age: '0, go: 1'b0, keep: 1'b1};
	assign tail_next = '{tag: '0, age: '0, go: 1'b0, keep: 1'b0};

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		apq_link_t prev_l;
		apq_link_t next_l;
		if (i == 0) begin : g_first
			assign prev_l = head_prev;
		end else begin : g_mid
			assign prev_l = links[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_l = tail_next;
		end else begin : g_inner
			assign next_l = links[i+1];
		end
		apq_cell u_cell (
			.clk  (clk),
			.ctrl (ctrl),
			.occ  (cnt_q > IDX),
			.prev (prev_l),
			.next (next_l),
			.cur  (links[i])
		);
	end

	// next count and result status
	always_comb begin
		cnt_nxt    = cnt_q;
		status_nxt = STATUS_OK;
		valid_nxt  = 1'b0;
		case (kind)
			KIND_ENQ: begin
				if (full) status_nxt = STATUS_FULL;
				else      cnt_nxt    = cnt_q + 1'b1;
			end
			KIND_DEQ: begin
				if (empty) status_nxt = STATUS_EMPTY;
				else begin
					valid_nxt = 1'b1;
					cnt_nxt   = cnt_q - 1'b1;
				end
			end
			KIND_PEEK: begin
				if (empty) status_nxt = STATUS_EMPTY;
				else       valid_nxt  = 1'b1;
			end
			default: ;
		endcase
	end

	// entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (take) cnt_q <= cnt_nxt;
			if (take)          m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (take) begin
			status_q     <= status_nxt;
			item_valid_q <= valid_nxt;
			occ_q        <= OCC_W'(cnt_nxt);
			if (valid_nxt) begin
				head_tag_q <= links[0].tag;
				head_age_q <= links[0].age;
				head_pri_q <= age_class(links[0].age);
			end else begin
				head_tag_q <= '0;
				head_age_q <= '0;
				head_pri_q <= '0;
			end
		end
	end

	assign m_tdata = {occ_q, head_pri_q, head_age_q, head_tag_q};
	assign m_tuser = {item_valid_q, status_q};

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// testbench for the age priority queue: directed and random request beats checked against a sorted model
module tb;
	import apq_pkg::*;

	localparam int unsigned RUN_BEATS   = 2000;
	localparam int unsigned TAIL_BEATS  = 200;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned HOLD_CYCLES = 80;
	localparam int unsigned HOLD_AFTER  = 300;
	localparam int unsigned REPORT_MAX  = 10;
	localparam int unsigned DRAIN_WAIT  = 8;

	// one result beat as the block should return it
	typedef struct packed {
		status_t          status;
		logic             item_valid;
		logic [TAG_W-1:0] head_tag;
		logic [AGE_W-1:0] head_age;
		logic [PRI_W-1:0] head_priority;
		logic [OCC_W-1:0] occupancy;
	} head_result_t;

	// sorted copy of the queue and the results still owed by the block
	class apq_scoreboard;
		logic [TAG_W-1:0] slot_tag [DEPTH_DEF];
		logic [AGE_W-1:0] slot_age [DEPTH_DEF];
		int unsigned      fill;
		head_result_t     heads_due [$];
		int unsigned      mismatches;
		int unsigned      results_seen;

		function new();
			fill = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		// priority band of an age: tens from sixty upwards, capped at five
		function logic [PRI_W-1:0] band_of(logic [AGE_W-1:0] a);
			if (a >= 8'd100) return 3'd5;
			if (a < 8'd60) return 3'd0;
			return PRI_W'((a - 8'd50) / 8'd10);
		endfunction

		// apply an accepted request to the model and queue its result
		function void note_request(kind_t k, logic [TAG_W-1:0] t, logic [AGE_W-1:0] a);
			head_result_t r;
			int unsigned  pos;
			r = '0;
			r.status = STATUS_OK;
			case (k)
				KIND_ENQ: begin
					if (fill >= DEPTH_DEF) begin
						r.status = STATUS_FULL;
					end else begin
						// younger entries move one slot back, equal ages stay ahead
						pos = fill;
						while (pos > 0 && slot_age[pos-1] < a) begin
							slot_tag[pos] = slot_tag[pos-1];
							slot_age[pos] = slot_age[pos-1];
							pos--;
						end
						slot_tag[pos] = t;
						slot_age[pos] = a;
						fill++;
					end
				end
				KIND_DEQ, KIND_PEEK: begin
					if (fill == 0) begin
						r.status = STATUS_EMPTY;
					end else begin
						r.item_valid    = 1'b1;
						r.head_tag      = slot_tag[0];
						r.head_age      = slot_age[0];
						r.head_priority = band_of(slot_age[0]);
						if (k == KIND_DEQ) begin
							for (int i = 1; i < fill; i++) begin
								slot_tag[i-1] = slot_tag[i];
								slot_age[i-1] = slot_age[i];
							end
							fill--;
						end
					end
				end
				default: ;
			endcase
			r.occupancy = OCC_W'(fill);
			heads_due.push_back(r);
		endfunction

		function void report(string what);
			mismatches++;
			if (mismatches <= REPORT_MAX) $display("mismatch: %s", what);
		endfunction

		// compare one result beat with the oldest expectation
		function void check_result(logic [OUT_DATA_W-1:0] d, logic [OUT_USER_W-1:0] u);
			head_result_t e;
			head_result_t g;
			results_seen++;
			g.head_tag      = d[15:0];
			g.head_age      = d[23:16];
			g.head_priority = d[26:24];
			g.occupancy     = d[31:27];
			g.status        = status_t'(u[1:0]);
			g.item_valid    = u[2];
			if (heads_due.size() == 0) begin
				report($sformatf("result beat %0d with nothing expected", results_seen));
				return;
			end
			e = heads_due.pop_front();
			if (g.status != e.status || g.item_valid != e.item_valid ||
					g.head_tag != e.head_tag || g.head_age != e.head_age ||
					g.head_priority != e.head_priority || g.occupancy != e.occupancy)
				report($sformatf({"beat %0d exp st=%0d v=%0d tag=%h age=%0d pri=%0d occ=%0d",
					" got st=%0d v=%0d tag=%h age=%0d pri=%0d occ=%0d"}, results_seen,
					e.status, e.item_valid, e.head_tag, e.head_age, e.head_priority,
					e.occupancy, g.status, g.item_valid, g.head_tag, g.head_age,
					g.head_priority, g.occupancy));
		endfunction

		function int unsigned pending();
			return heads_due.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;  // tag[15:0], age[23:16]
	logic [KIND_W-1:0]     s_tuser;  // kind[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;  // head_tag, head_age, head_priority, occupancy
	logic [OUT_USER_W-1:0] m_tuser;  // status[1:0], item_valid[2]

	apq_scoreboard sb = new();
	bit            quiet;
	bit            held;
	int unsigned   stall_cycles;

	logic [AGE_W-1:0] seed_ages [16] = '{8'd0, 8'd255, 8'd59, 8'd60, 8'd69, 8'd70, 8'd79,
		8'd80, 8'd89, 8'd90, 8'd99, 8'd100, 8'd100, 8'd255, 8'd1, 8'd60};

	age_priority_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// offer one request beat and hold it until taken
	task automatic send_beat(kind_t k, logic [TAG_W-1:0] t, logic [AGE_W-1:0] a);
		s_tvalid <= 1'b1;
		s_tdata  <= {a, t};
		s_tuser  <= k;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic pause(int unsigned n);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// ages: boundaries, the class range, a few repeated values for ties, or anything
	function automatic logic [AGE_W-1:0] pick_age();
		logic [AGE_W-1:0] a;
		case ($urandom_range(3))
			0: a = seed_ages[$urandom_range(15)];
			1: a = AGE_W'($urandom_range(105, 55));
			2: a = AGE_W'(40 + 10 * $urandom_range(7));
			default: a = AGE_W'($urandom);
		endcase
		return a;
	endfunction

	// accepted beats on both sides, plus the stall watchdog
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			sb.note_request(kind_t'(s_tuser), s_tdata[15:0], s_tdata[23:16]);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser);
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// receiver: random back-pressure bursts, one long hold to fill the block
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && !held && sb.results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!quiet && $urandom_range(5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(9, 1)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// sender: directed beats, then phases of random traffic
	initial begin
		int unsigned n;
		int unsigned phase_beats;
		int unsigned enq_pct;
		int unsigned r;
		kind_t       k;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= KIND_NONE;
		quiet = 1'b0;
		held = 1'b0;
		stall_cycles = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, the unused kind, then fill with boundary ages and overfill
		send_beat(KIND_PEEK, 16'hffff, 8'hff);
		send_beat(KIND_DEQ, 16'h0000, 8'h00);
		send_beat(KIND_NONE, 16'hffff, 8'hff);
		for (int i = 0; i < 16; i++)
			send_beat(KIND_ENQ, (i == 0) ? 16'h0000 : (i == 1) ? 16'hffff : TAG_W'($urandom),
				seed_ages[i]);
		send_beat(KIND_ENQ, 16'h5a5a, 8'd60);
		send_beat(KIND_PEEK, 16'h0000, 8'h00);
		send_beat(KIND_DEQ, 16'hffff, 8'hff);
		send_beat(KIND_DEQ, 16'h0000, 8'h00);

		// random part: the enqueue share changes per phase so the fill sweeps full and empty
		n = 0;
		phase_beats = 0;
		enq_pct = 50;
		while (n < RUN_BEATS) begin
			if (phase_beats % 64 == 0) begin
				case ($urandom_range(3))
					0: enq_pct = 15;
					1: enq_pct = 85;
					default: enq_pct = 50;
				endcase
			end
			phase_beats++;
			quiet = (n >= RUN_BEATS - TAIL_BEATS);
			if (!quiet && $urandom_range(4) == 0)
				pause($urandom_range(9, 1));
			r = $urandom_range(99);
			if (r < 3)
				k = KIND_NONE;
			else if (r < 3 + enq_pct)
				k = KIND_ENQ;
			else if ($urandom_range(3) == 0)
				k = KIND_PEEK;
			else
				k = KIND_DEQ;
			send_beat(k, TAG_W'($urandom), pick_age());
			if (k != KIND_NONE) n++;
		end
		s_tvalid <= 1'b0;

		// drain, then keep watching for stray beats before the verdict
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/apq_pkg.sv
hw/rtl/apq_cell.sv
hw/rtl/age_priority_queue.sv
tb/tb.sv
